// ----- rtl/core/color_grade_affine_gamma_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the color grade block
// Shared property forms used by the checker of the color grade block.
// ----------------------------------------------------------------------------
`ifndef COLOR_GRADE_AFFINE_GAMMA_ASSERT_SVH
`define COLOR_GRADE_AFFINE_GAMMA_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cga_pkg.sv -----
// ----------------------------------------------------------------------------
// Color grade package
// Types and fixed constants shared by the color grade pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cga_pkg;

   localparam int NUM_CH    = 3;
   localparam int CH_W      = 16;
   localparam int LOG_BITS  = 16;
   localparam int MANT_FRAC = 30;
   localparam int LOG_W     = 24;

   // Square root datapath: radicand, partial remainder and digit steps per stage.
   localparam int SQRT_RAD_W           = 64;
   localparam int SQRT_REM_W           = 34;
   localparam int SQRT_STEPS_PER_STAGE = 4;
   localparam int SQRT_STAGES          = SQRT_RAD_W / 2 / SQRT_STEPS_PER_STAGE;

   // Affine, normalize, log squarings, exponent multiply, exp2 roots, shift, clamp.
   localparam int CGA_LATENCY = 3 + LOG_BITS + 1 + LOG_BITS * SQRT_STAGES + 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_DATA_W-1:0] UNITY_X3 = 48'h1000_1000_1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCALES      = 3'd0,
      REG_OFFSETS     = 3'd1,
      REG_INV_GAMMAS  = 3'd2,
      REG_CLAMP_BLACK = 3'd3,
      REG_CLAMP_WHITE = 3'd4
   } cga_reg_type;

   typedef struct packed {
      logic signed [CH_W-1:0] red_in;
      logic signed [CH_W-1:0] green_in;
      logic signed [CH_W-1:0] blue_in;
   } cga_req_type;

   typedef struct packed {
      logic signed [CH_W-1:0] red_out;
      logic signed [CH_W-1:0] green_out;
      logic signed [CH_W-1:0] blue_out;
   } cga_rsp_type;

   typedef struct packed {
      logic signed [CH_W-1:0] scale;
      logic signed [CH_W-1:0] offset;
      logic [CH_W-1:0]        igamma;
      logic                   clamp_black;
      logic                   clamp_white;
   } cga_chan_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/cga_sqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined square root step of the exp2 chain
// Computes floor(sqrt(r * (1 + b) * 2^30)) over several register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_sqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                         clock,
   input  logic [cga_pkg::MANT_FRAC:0]  root_in,
   input  logic                         bit_in,
   input  logic [SIDE_W-1:0]            side_in,
   output logic [cga_pkg::MANT_FRAC:0]  root_out,
   output logic [SIDE_W-1:0]            side_out
);
   import cga_pkg::*;

   localparam int RW = MANT_FRAC + 1;

   logic [SQRT_RAD_W-1:0] rad_ff  [SQRT_STAGES];
   logic [SQRT_RAD_W-1:0] rad_in  [SQRT_STAGES];
   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [SQRT_REM_W-1:0] rem_in  [SQRT_STAGES];
   logic [RW-1:0]         q_ff    [SQRT_STAGES];
   logic [RW-1:0]         q_in    [SQRT_STAGES];
   logic [SIDE_W-1:0]     side_ff [SQRT_STAGES];

   logic [RW:0]           scaled;
   logic [SQRT_RAD_W-1:0] rad_first;

   always_comb begin
      scaled    = bit_in ? {root_in, 1'b0} : {1'b0, root_in};
      rad_first = {2'b00, scaled, {MANT_FRAC{1'b0}}};
   end

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic [SQRT_RAD_W-1:0] rad_src;
      logic [SQRT_REM_W-1:0] rem_src;
      logic [RW-1:0]         q_src;
      logic [SIDE_W-1:0]     side_src;

      if (s == 0) begin : g_head
         assign rad_src  = rad_first;
         assign rem_src  = '0;
         assign q_src    = '0;
         assign side_src = side_in;
      end else begin : g_body
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // Restoring digit recurrence, two radicand bits per result bit.
      always_comb begin
         logic [SQRT_RAD_W-1:0] rad_w;
         logic [SQRT_REM_W-1:0] rem_w;
         logic [SQRT_REM_W-1:0] trial;
         logic [RW-1:0]         q_w;
         rad_w = rad_src;
         rem_w = rem_src;
         q_w   = q_src;
         for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
            rem_w = {rem_w[SQRT_REM_W-3:0], rad_w[SQRT_RAD_W-1 -: 2]};
            trial = {1'b0, q_w, 2'b01};
            if (rem_w >= trial) begin
               rem_w = rem_w - trial;
               q_w   = {q_w[RW-2:0], 1'b1};
            end else begin
               q_w   = {q_w[RW-2:0], 1'b0};
            end
            rad_w = rad_w << 2;
         end
         rad_in[s] = rad_w;
         rem_in[s] = rem_w;
         q_in[s]   = q_w;
      end

      always_ff @(posedge clock) begin
         rad_ff[s]  <= rad_in[s];
         rem_ff[s]  <= rem_in[s];
         q_ff[s]    <= q_in[s];
         side_ff[s] <= side_src;
      end
   end

   assign root_out = q_ff[SQRT_STAGES-1];
   assign side_out = side_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/cga_channel.sv -----
// ----------------------------------------------------------------------------
// Color grade channel pipeline
// Affine transform, log2 by squaring, exponent multiply, exp2 by square roots,
// rounding shift, clamps and saturation for one color channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_channel #(
   parameter int FRAC_BITS = 12
) (
   input  logic                             clock,
   input  cga_pkg::cga_chan_cfg_type        cfg,
   input  logic signed [cga_pkg::CH_W-1:0]  pix_in,
   output logic [cga_pkg::CH_W-1:0]         pix_out
);
   import cga_pkg::*;

   localparam int SUM_W  = ((FRAC_BITS > 16) ? 16 + FRAC_BITS : 32) + 2;
   localparam int C_W    = SUM_W - FRAC_BITS;
   localparam int E_W    = $clog2(C_W);
   localparam int MR_W   = MANT_FRAC + 1;
   localparam int V_W    = 34;
   localparam int PROD_W = LOG_W + CH_W + 1;
   localparam int Y_W    = PROD_W - FRAC_BITS;
   localparam int N_W    = Y_W - LOG_BITS;
   localparam int K_W    = N_W + 7;
   localparam int SIDE_W = Y_W + CH_W + 1;
   localparam int SH_W   = $clog2(MR_W + 1);

   localparam logic signed [V_W-1:0]  ONE_V = V_W'(1) << FRAC_BITS;
   localparam logic signed [V_W-1:0]  MAX_V = V_W'(32767);
   localparam logic signed [V_W-1:0]  MIN_V = -(V_W'(32768));
   localparam logic [MR_W-1:0]        PW_SAT = MR_W'(32767);

   function automatic logic [CH_W-1:0] grade_sat(input logic signed [V_W-1:0] v,
                                                 input logic cb, input logic cwh);
      logic signed [V_W-1:0] t;
      t = v;
      if (cb && (t < 0)) t = '0;
      if (cwh && (t > ONE_V)) t = ONE_V;
      if (t > MAX_V) t = MAX_V;
      if (t < MIN_V) t = MIN_V;
      return t[CH_W-1:0];
   endfunction

   // Affine stages.
   logic signed [31:0]    prod_ff, prod_in;
   logic signed [SUM_W-1:0] sum_w;
   logic signed [C_W-1:0] c_ff, c_in;

   always_comb begin
      prod_in = cfg.scale * pix_in;
      sum_w   = SUM_W'(prod_ff) + (SUM_W'(cfg.offset) <<< FRAC_BITS)
              + (SUM_W'(1) << (FRAC_BITS - 1));
      c_in    = sum_w[SUM_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      c_ff    <= c_in;
   end

   // Normalize and resolve the non-positive bases.
   logic [MR_W-1:0] m0_ff, m0_in;
   logic [E_W-1:0]  e0_ff, e0_in;
   logic [CH_W-1:0] alt0_ff, alt0_in;
   logic            use0_ff, use0_in;

   always_comb begin
      e0_in = '0;
      for (int i = 0; i < C_W - 1; i++) begin
         if (c_ff[i]) e0_in = E_W'(i);
      end
      m0_in   = MR_W'(c_ff[C_W-2:0]) << (MANT_FRAC - int'(e0_in));
      use0_in = c_ff[C_W-1] || (c_ff == '0);
      if (c_ff[C_W-1]) begin
         alt0_in = grade_sat(V_W'(c_ff), cfg.clamp_black, cfg.clamp_white);
      end else begin
         alt0_in = grade_sat((cfg.igamma == '0) ? ONE_V : '0,
                             cfg.clamp_black, cfg.clamp_white);
      end
   end

   always_ff @(posedge clock) begin
      m0_ff   <= m0_in;
      e0_ff   <= e0_in;
      alt0_ff <= alt0_in;
      use0_ff <= use0_in;
   end

   // log2 fraction, one bit per squaring stage.
   logic [MR_W-1:0]     lm_ff    [LOG_BITS];
   logic [MR_W-1:0]     lm_in    [LOG_BITS];
   logic [LOG_BITS-1:0] lfrac_ff [LOG_BITS];
   logic [LOG_BITS-1:0] lfrac_in [LOG_BITS];
   logic [E_W-1:0]      le_ff    [LOG_BITS];
   logic [CH_W-1:0]     lalt_ff  [LOG_BITS];
   logic                luse_ff  [LOG_BITS];

   for (genvar j = 0; j < LOG_BITS; j++) begin : g_log
      logic [MR_W-1:0]     m_src;
      logic [LOG_BITS-1:0] frac_src;
      logic [E_W-1:0]      e_src;
      logic [CH_W-1:0]     alt_src;
      logic                use_src;

      if (j == 0) begin : g_head
         assign m_src    = m0_ff;
         assign frac_src = '0;
         assign e_src    = e0_ff;
         assign alt_src  = alt0_ff;
         assign use_src  = use0_ff;
      end else begin : g_body
         assign m_src    = lm_ff[j-1];
         assign frac_src = lfrac_ff[j-1];
         assign e_src    = le_ff[j-1];
         assign alt_src  = lalt_ff[j-1];
         assign use_src  = luse_ff[j-1];
      end

      always_comb begin
         logic [2*MR_W-1:0] sq;
         logic [MR_W:0]     top;
         sq  = m_src * m_src;
         top = sq[MANT_FRAC +: MR_W + 1];
         if (top[MR_W]) begin
            lm_in[j]    = top[MR_W:1];
            lfrac_in[j] = {frac_src[LOG_BITS-2:0], 1'b1};
         end else begin
            lm_in[j]    = top[MR_W-1:0];
            lfrac_in[j] = {frac_src[LOG_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         lm_ff[j]    <= lm_in[j];
         lfrac_ff[j] <= lfrac_in[j];
         le_ff[j]    <= e_src;
         lalt_ff[j]  <= alt_src;
         luse_ff[j]  <= use_src;
      end
   end

   // Exponent multiply: y = floor(L * G / 2^F).
   logic signed [LOG_W-1:0]  ediff_w, lg_w;
   logic signed [PROD_W-1:0] gprod_w;
   logic [Y_W-1:0]           y_ff, y_in;
   logic [CH_W-1:0]          yalt_ff;
   logic                     yuse_ff;

   always_comb begin
      ediff_w = LOG_W'(le_ff[LOG_BITS-1]) - LOG_W'(FRAC_BITS);
      lg_w    = (ediff_w <<< LOG_BITS) + LOG_W'(lfrac_ff[LOG_BITS-1]);
      gprod_w = lg_w * $signed({1'b0, cfg.igamma});
      y_in    = gprod_w[PROD_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      yalt_ff <= lalt_ff[LOG_BITS-1];
      yuse_ff <= luse_ff[LOG_BITS-1];
   end

   // exp2 of the fraction, one square root per fraction bit, lsb first.
   logic [MR_W-1:0]   root_w [LOG_BITS+1];
   logic [SIDE_W-1:0] side_w [LOG_BITS+1];

   assign root_w[0] = MR_W'(1) << MANT_FRAC;
   assign side_w[0] = {y_ff, yalt_ff, yuse_ff};

   for (genvar j = 0; j < LOG_BITS; j++) begin : g_exp
      cga_sqrt #(
         .SIDE_W (SIDE_W)
      ) u_sqrt (
         .clock    (clock),
         .root_in  (root_w[j]),
         .bit_in   (side_w[j][CH_W + 1 + j]),
         .side_in  (side_w[j]),
         .root_out (root_w[j+1]),
         .side_out (side_w[j+1])
      );
   end

   // Scale by 2^(n + F - 30) with rounding.
   logic [Y_W-1:0]          fy_w;
   logic signed [N_W-1:0]   n_w;
   logic signed [K_W-1:0]   k_w;
   logic [SH_W-1:0]         sh_w;
   logic [MR_W:0]           tmp_w;
   logic [MR_W-1:0]         pw_ff, pw_in;
   logic [CH_W-1:0]         falt_ff;
   logic                    fuse_ff;
   logic [CH_W-1:0]         out_ff, out_in;

   always_comb begin
      fy_w  = side_w[LOG_BITS][SIDE_W-1:CH_W+1];
      n_w   = fy_w[Y_W-1:LOG_BITS];
      k_w   = K_W'(MANT_FRAC - FRAC_BITS) - K_W'(n_w);
      sh_w  = '0;
      tmp_w = '0;
      if (k_w <= 0) begin
         pw_in = PW_SAT;
      end else if (k_w > K_W'(MR_W + 1)) begin
         pw_in = '0;
      end else begin
         sh_w  = SH_W'(k_w - 1);
         tmp_w = ({1'b0, root_w[LOG_BITS]} >> sh_w) + (MR_W + 1)'(1);
         pw_in = tmp_w[MR_W:1];
      end
      out_in = fuse_ff ? falt_ff
                       : grade_sat(V_W'(pw_ff), cfg.clamp_black, cfg.clamp_white);
   end

   always_ff @(posedge clock) begin
      pw_ff   <= pw_in;
      falt_ff <= side_w[LOG_BITS][CH_W:1];
      fuse_ff <= side_w[LOG_BITS][0];
      out_ff  <= out_in;
   end

   assign pix_out = out_ff;

endmodule

`default_nettype wire

// ----- rtl/core/color_grade_affine_gamma.sv -----
// ----------------------------------------------------------------------------
// Color grade, affine plus gamma
// Grades one signed fixed point RGB pixel per clock: scale and offset, then a
// per-channel power by log2 and exp2, then clamps and saturation.
// ----------------------------------------------------------------------------
// A request is taken at every rising edge where start is high and busy is low,
// and busy is high only during reset and the cycle after it, so a new pixel
// can enter on every clock. The graded pixel appears on rsp_pixel with
// rsp_strobe high for exactly one cycle once its request has passed every stage;
// results leave in request order and the receiver cannot hold them off.
// Most of the depth lies in the exp2 stage, a chain of sixteen pipelined square
// roots of eight stages each, behind sixteen squaring stages for log2.
// Configuration registers are written through csr_we, csr_index and csr_wdata
// and must only be changed while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module color_grade_affine_gamma #(
   parameter int FRAC_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  cga_pkg::cga_req_type                  req_pixel,
   output logic                                  rsp_strobe,
   output cga_pkg::cga_rsp_type                  rsp_pixel,
   input  logic                                  csr_we,
   input  logic [cga_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cga_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import cga_pkg::*;

   // Configuration registers. Each packed register holds red in its low
   // sixteen bits, then green, then blue.
   logic [CSR_DATA_W-1:0] scales_ff, scales_in;
   logic [CSR_DATA_W-1:0] offsets_ff, offsets_in;
   logic [CSR_DATA_W-1:0] igammas_ff, igammas_in;
   logic                  cblack_ff, cblack_in;
   logic                  cwhite_ff, cwhite_in;

   always_comb begin
      scales_in  = scales_ff;
      offsets_in = offsets_ff;
      igammas_in = igammas_ff;
      cblack_in  = cblack_ff;
      cwhite_in  = cwhite_ff;
      if (csr_we) begin
         unique case (cga_reg_type'(csr_index))
            REG_SCALES:      scales_in  = csr_wdata;
            REG_OFFSETS:     offsets_in = csr_wdata;
            REG_INV_GAMMAS:  igammas_in = csr_wdata;
            REG_CLAMP_BLACK: cblack_in  = csr_wdata[0];
            REG_CLAMP_WHITE: cwhite_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scales_ff  <= UNITY_X3;
         offsets_ff <= '0;
         igammas_ff <= UNITY_X3;
         cblack_ff  <= 1'b1;
         cwhite_ff  <= 1'b0;
      end else begin
         scales_ff  <= scales_in;
         offsets_ff <= offsets_in;
         igammas_ff <= igammas_in;
         cblack_ff  <= cblack_in;
         cwhite_ff  <= cwhite_in;
      end
   end

   // Valid bits move one stage per clock alongside the channel datapaths.
   // Nothing downstream can stall, so the line never holds.
   logic                   accept;
   logic                   busy_ff;
   logic [CGA_LATENCY-1:0] valid_ff, valid_in;

   assign accept   = start && !busy_ff;
   assign valid_in = {valid_ff[CGA_LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= 1'b0;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = valid_ff[CGA_LATENCY-1];

   // The three channels run identical, independent pipelines.
   logic signed [CH_W-1:0] pix_in  [NUM_CH];
   logic [CH_W-1:0]        pix_out [NUM_CH];

   assign pix_in[0] = req_pixel.red_in;
   assign pix_in[1] = req_pixel.green_in;
   assign pix_in[2] = req_pixel.blue_in;

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
      cga_chan_cfg_type cfg_w;

      assign cfg_w = '{
         scale:       scales_ff[ch*CH_W +: CH_W],
         offset:      offsets_ff[ch*CH_W +: CH_W],
         igamma:      igammas_ff[ch*CH_W +: CH_W],
         clamp_black: cblack_ff,
         clamp_white: cwhite_ff
      };

      cga_channel #(
         .FRAC_BITS (FRAC_BITS)
      ) u_channel (
         .clock   (clock),
         .cfg     (cfg_w),
         .pix_in  (pix_in[ch]),
         .pix_out (pix_out[ch])
      );
   end

   assign rsp_pixel = '{
      red_out:   pix_out[0],
      green_out: pix_out[1],
      blue_out:  pix_out[2]
   };

endmodule

`default_nettype wire

// ----- rtl/core/cga_checker.sv -----
// ----------------------------------------------------------------------------
// Color grade port checker
// Timing checks on the ports of the color grade block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_grade_affine_gamma_assert.svh"

module cga_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);
   import cga_pkg::*;

   // Reset raises busy and leaves no result behind.
   `CGA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, busy && !rsp_strobe, "reset not quiet")

   // Busy lasts only one cycle once reset has gone.
   `CGA_ASSERT_NEXT(a_busy_short, clock, reset, busy && !reset, !busy, "busy held too long")

   // Every result belongs to a request taken a fixed latency earlier.
   `CGA_ASSERT_NOW(a_strobe_origin, clock, reset, rsp_strobe, $past(start && !busy, CGA_LATENCY), "result without request")

endmodule

bind color_grade_affine_gamma cga_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire

// ----- test/color_grade_checker.sv -----
// ----------------------------------------------------------------------------
// Color grade checker
// Watches the request, response and register channels of the color grade
// block, predicts every graded pixel and compares it with the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module color_grade_checker #(
   parameter int FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  cga_pkg::cga_req_type                req_pixel,
   input  logic                                rsp_strobe,
   input  cga_pkg::cga_rsp_type                rsp_pixel,
   input  logic                                csr_we,
   input  logic [cga_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cga_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  pixels_waiting,
   output int                                  pixels_checked
);
   import cga_pkg::*;

   logic [47:0] scales, offsets, igammas;
   logic        black_on, white_on;
   cga_rsp_type graded_q[$];

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Power of a positive base by log2, multiply, exp2, all in integers.
   function automatic longint raise_pos(longint c, longint unsigned g);
      longint unsigned uc, m, r, frac, f, b;
      longint          lg, y, n, sh;
      int              e;
      uc   = c;
      e    = 63;
      frac = 0;
      while (e > 0 && uc[e] == 1'b0) e--;
      if (e <= MANT_FRAC) m = uc << (MANT_FRAC - e);
      else m = uc >> (e - MANT_FRAC);
      for (int i = 0; i < LOG_BITS; i++) begin
         m    = (m * m) >> MANT_FRAC;
         frac = frac << 1;
         if (m >= (64'd2 << MANT_FRAC)) begin
            m    = m >> 1;
            frac = frac | 1;
         end
      end
      lg = longint'(e - FRAC_BITS) * (64'sd1 <<< LOG_BITS) + longint'(frac);
      y  = (lg * longint'(g)) >>> FRAC_BITS;
      n  = y >>> LOG_BITS;
      f  = y - n * (64'sd1 <<< LOG_BITS);
      r  = 64'd1 << MANT_FRAC;
      for (int i = 0; i < LOG_BITS; i++) begin
         b = (f >> i) & 1;
         r = floor_sqrt((r * (1 + b)) << MANT_FRAC);
      end
      sh = n + FRAC_BITS - MANT_FRAC;
      if (sh >= 0) return 32767;
      if (-sh >= 63) return 0;
      return longint'((r + (64'd1 << (-sh - 1))) >> (-sh));
   endfunction

   function automatic logic signed [15:0] grade_one(logic signed [15:0] x, int ch);
      longint a, ofs, c, v, one;
      longint unsigned g;
      a   = longint'($signed(scales[ch*16 +: 16]));
      ofs = longint'($signed(offsets[ch*16 +: 16]));
      g   = igammas[ch*16 +: 16];
      one = 64'sd1 <<< FRAC_BITS;
      c   = (a * longint'(x) + ofs * one + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (c < 0) v = c;
      else if (c == 0) v = (g == 0) ? one : 0;
      else v = raise_pos(c, g);
      if (black_on && v < 0) v = 0;
      if (white_on && v > one) v = one;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic cga_rsp_type grade_pixel(cga_req_type p);
      cga_rsp_type o;
      o.red_out   = grade_one(p.red_in, 0);
      o.green_out = grade_one(p.green_in, 1);
      o.blue_out  = grade_one(p.blue_in, 2);
      return o;
   endfunction

   always @(posedge clock) begin
      cga_rsp_type want;
      if (reset) begin
         scales         <= UNITY_X3;
         offsets        <= '0;
         igammas        <= UNITY_X3;
         black_on       <= 1'b1;
         white_on       <= 1'b0;
         fail_count     <= 0;
         pixels_checked <= 0;
         pixels_waiting <= 0;
         graded_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SCALES:      scales   <= csr_wdata;
               REG_OFFSETS:     offsets  <= csr_wdata;
               REG_INV_GAMMAS:  igammas  <= csr_wdata;
               REG_CLAMP_BLACK: black_on <= csr_wdata[0];
               REG_CLAMP_WHITE: white_on <= csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) graded_q.push_back(grade_pixel(req_pixel));
         if (rsp_strobe) begin
            if (graded_q.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected response %h", rsp_pixel);
               fail_count <= fail_count + 1;
            end else begin
               want = graded_q.pop_front();
               pixels_checked <= pixels_checked + 1;
               if (want !== rsp_pixel) begin
                  if (fail_count < 10)
                     $display("ERROR: pixel %0d expected r %h g %h b %h got r %h g %h b %h",
                              pixels_checked, want.red_out, want.green_out, want.blue_out,
                              rsp_pixel.red_out, rsp_pixel.green_out, rsp_pixel.blue_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pixels_waiting <= graded_q.size();
      end
   end
endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Color grade testbench
// Drives pixels through the color grade block under a series of register
// settings and idle patterns; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import cga_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   cga_req_type            req_pixel = '0;
   logic                   rsp_strobe;
   cga_rsp_type            rsp_pixel;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     fail_count, pixels_waiting, pixels_checked;
   int                     cycles = 0;
   int                     sent = 0;
   int                     idle_pct = 0;

   localparam int CYCLE_LIMIT = 400000;

   always #2 clock = ~clock;

   color_grade_affine_gamma dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel(req_pixel), .rsp_strobe(rsp_strobe), .rsp_pixel(rsp_pixel),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   color_grade_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel(req_pixel), .rsp_strobe(rsp_strobe), .rsp_pixel(rsp_pixel),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pixels_waiting(pixels_waiting),
      .pixels_checked(pixels_checked)
   );

   // A watchdog: a hung handshake must not hang the run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // One register write; only called while no request is in flight.
   task automatic write_reg(cga_reg_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Presents a request, holds it until taken, then idles at random.
   task automatic send_pixel(cga_req_type p);
      int gap;
      start     <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (busy);
      sent++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Channel values lean toward the interesting zone near zero and one,
   // with a share drawn from the whole range.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(65535);
         1: return $urandom_range(4096);
         2: return $urandom_range(8192);
         default: return 16'($signed($urandom_range(600)) - 300);
      endcase
   endfunction

   function automatic cga_req_type rand_pixel();
      cga_req_type p;
      p.red_in   = pick_value();
      p.green_in = pick_value();
      p.blue_in  = pick_value();
      return p;
   endfunction

   function automatic logic [47:0] rand3(bit narrow);
      logic [47:0] v;
      for (int i = 0; i < 3; i++)
         v[i*16 +: 16] = narrow ? 16'($urandom_range(1024, 8192)) : 16'($urandom_range(65535));
      return v;
   endfunction

   // Settle the pipeline: start stays low and every graded pixel comes back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pixels_waiting != 0) @(posedge clock);
   endtask

   initial begin
      cga_req_type p;
      logic [15:0] edge_vals[8] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                                     16'hffff, 16'h1000, 16'h0800, 16'h2000};
      int          pct_list[5] = '{0, 69, 0, 16, 69};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under reset settings: field extremes, zero base,
      // negative base clamped to black, values near one.
      foreach (edge_vals[i]) begin
         p.red_in   = edge_vals[i];
         p.green_in = edge_vals[(i + 3) % 8];
         p.blue_in  = edge_vals[(i + 5) % 8];
         send_pixel(p);
      end
      drain();

      // Zero exponent and zero base with both clamps off, then the largest exponent
      // with both on; extreme scales push the affine step past the output range.
      write_reg(REG_INV_GAMMAS, 48'h0000_0000_0000);
      write_reg(REG_CLAMP_BLACK, 48'd0);
      write_reg(REG_SCALES, 48'h7fff_8000_7fff);
      write_reg(REG_OFFSETS, 48'h8000_7fff_0000);
      foreach (edge_vals[i]) begin
         p.red_in   = edge_vals[i];
         p.green_in = edge_vals[(i + 1) % 8];
         p.blue_in  = edge_vals[(i + 2) % 8];
         send_pixel(p);
      end
      drain();
      write_reg(REG_INV_GAMMAS, 48'hffff_ffff_ffff);
      write_reg(REG_CLAMP_WHITE, 48'd1);
      write_reg(REG_CLAMP_BLACK, 48'd1);
      foreach (edge_vals[i]) begin
         p.red_in   = edge_vals[i];
         p.green_in = edge_vals[7 - i];
         p.blue_in  = edge_vals[(i + 4) % 8];
         send_pixel(p);
      end
      drain();

      // Random phases: each gets fresh settings and an idle pattern. The
      // drain between phases is where the sender waits for every response.
      for (int ph = 0; ph < 10; ph++) begin
         idle_pct = pct_list[ph % 5];
         write_reg(REG_SCALES, (ph % 3 == 0) ? rand3(0) : rand3(1));
         write_reg(REG_OFFSETS, (ph % 2 == 0) ? rand3(0) & 48'h8fff_8fff_8fff : '0);
         write_reg(REG_INV_GAMMAS, (ph % 4 == 3) ? rand3(0) : rand3(1));
         write_reg(REG_CLAMP_BLACK, 48'($urandom_range(1)));
         write_reg(REG_CLAMP_WHITE, 48'($urandom_range(1)));
         write_reg(cga_reg_type'(3'd7), rand3(0));
         repeat (112) send_pixel(rand_pixel());
         drain();
      end

      repeat (CGA_LATENCY + 10) @(posedge clock);
      $display("Sent %0d pixels and checked %0d responses over ten register settings,",
               sent, pixels_checked);
      $display("covering field extremes, zero exponent, both clamps and idle gaps.");
      if (fail_count == 0 && pixels_waiting == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
